### hw/rtl/afu_pkg.sv
// Shared types, constants and the sigmoid table for the activation unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package afu_pkg;

    localparam int DATA_W                = 16;
    localparam int SIGMOID_TABLE_ENTRIES = 256;
    localparam int FRACTION_BITS         = 11;

    localparam int ONE_Q     = 1 << FRACTION_BITS;
    localparam int ROM_W     = FRACTION_BITS + 1;
    localparam int IDX_W     = $clog2(SIGMOID_TABLE_ENTRIES + 1);
    localparam int POS_SHIFT = FRACTION_BITS + 3;
    localparam int P_W       = (DATA_W + IDX_W > POS_SHIFT + IDX_W) ?
                               DATA_W + IDX_W : POS_SHIFT + IDX_W;
    localparam int OM_W      = (FRACTION_BITS + 2 > DATA_W + 1) ?
                               FRACTION_BITS + 2 : DATA_W + 1;
    localparam int PROD_W    = DATA_W + OM_W;
    localparam int MUL_W     = ROM_W + POS_SHIFT;
    localparam int SIG_W     = ROM_W + 1;

    localparam int unsigned SIG_LIMIT = 32'd8 << FRACTION_BITS;

    localparam logic signed [DATA_W-1:0] ONE_SAT16 =
        (FRACTION_BITS >= 15) ? 16'sh7FFF : DATA_W'(ONE_Q);

    localparam logic [1:0] OP_RELU    = 2'd0;
    localparam logic [1:0] OP_SIGMOID = 2'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_value;
        logic [1:0]               opcode;
        logic                     want_derivative;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     invalid_kind;
    } t_out_item;

    typedef enum logic [2:0] {
        K_RELU,
        K_DRELU,
        K_SIG,
        K_DSIG,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  neg;
        logic  beyond;
    } t_ctl;

    typedef logic [ROM_W-1:0] t_rom [0:SIGMOID_TABLE_ENTRIES];

    // Long division by shift and subtract; evaluated only while building the table.
    function automatic logic [63:0] f_rom_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Points of 1/(1+e^-t) at t = 8*i/N, from a Q32 decay ratio e^-(8/N).
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        int          i;
        d    = (64'd1 << 35) / 64'(SIGMOID_TABLE_ENTRIES);
        term = 64'd1 << 32;
        r    = term;
        e    = term;
        term = ((term * d) >> 32) / 64'd1;  r = r - term;
        term = ((term * d) >> 32) / 64'd2;  r = r + term;
        term = ((term * d) >> 32) / 64'd3;  r = r - term;
        term = ((term * d) >> 32) / 64'd4;  r = r + term;
        term = ((term * d) >> 32) / 64'd5;  r = r - term;
        term = ((term * d) >> 32) / 64'd6;  r = r + term;
        term = ((term * d) >> 32) / 64'd7;  r = r - term;
        term = ((term * d) >> 32) / 64'd8;  r = r + term;
        term = ((term * d) >> 32) / 64'd9;  r = r - term;
        term = ((term * d) >> 32) / 64'd10; r = r + term;
        term = ((term * d) >> 32) / 64'd11; r = r - term;
        term = ((term * d) >> 32) / 64'd12; r = r + term;
        for (i = 0; i <= SIGMOID_TABLE_ENTRIES; i++) begin
            den    = (64'd1 << 32) + e;
            num    = (64'd1 << (FRACTION_BITS + 32)) + (den >> 1);
            rom[i] = ROM_W'(f_rom_div(num, den));
            e      = (e * r + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM = f_build_rom();

endpackage

### hw/rtl/afu_front.sv
// First stage: decode the kind, take |x|, form the table position and x*(1-x).
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  afu_pkg::t_in_item                        i_item,
    output afu_pkg::t_ctl                            o_ctl,
    output logic [afu_pkg::P_W-1:0]                  o_p,
    output logic signed [afu_pkg::PROD_W-1:0]        o_prod,
    output logic signed [afu_pkg::DATA_W-1:0]        o_fixed
);

    logic signed [afu_pkg::DATA_W-1:0] x;
    logic [afu_pkg::DATA_W-1:0]        x_u;
    logic [afu_pkg::DATA_W-1:0]        a;
    logic signed [afu_pkg::OM_W-1:0]   one_m;
    logic                              pos;

    afu_pkg::t_ctl                     n_ctl;
    logic [afu_pkg::P_W-1:0]           n_p;
    logic signed [afu_pkg::PROD_W-1:0] n_prod;
    logic signed [afu_pkg::DATA_W-1:0] n_fixed;

    afu_pkg::t_ctl                     r_ctl;
    logic [afu_pkg::P_W-1:0]           r_p;
    logic signed [afu_pkg::PROD_W-1:0] r_prod;
    logic signed [afu_pkg::DATA_W-1:0] r_fixed;

    always_comb begin
        x   = i_item.x_value;
        x_u = i_item.x_value;
        a   = x_u[afu_pkg::DATA_W-1] ? (~x_u + 1'b1) : x_u;
        pos = (x > 16'sd0);

        n_ctl.valid  = i_valid;
        n_ctl.neg    = x_u[afu_pkg::DATA_W-1];
        n_ctl.beyond = (32'(a) >= afu_pkg::SIG_LIMIT);
        case (i_item.opcode)
            afu_pkg::OP_RELU: begin
                n_ctl.kind = i_item.want_derivative ? afu_pkg::K_DRELU : afu_pkg::K_RELU;
            end
            afu_pkg::OP_SIGMOID: begin
                n_ctl.kind = i_item.want_derivative ? afu_pkg::K_DSIG : afu_pkg::K_SIG;
            end
            default: begin
                n_ctl.kind = afu_pkg::K_BAD;
            end
        endcase

        n_p    = afu_pkg::P_W'(a) * afu_pkg::P_W'(afu_pkg::SIGMOID_TABLE_ENTRIES);
        one_m  = afu_pkg::OM_W'(afu_pkg::ONE_Q) - afu_pkg::OM_W'(x);
        n_prod = afu_pkg::PROD_W'(x) * afu_pkg::PROD_W'(one_m);

        case (n_ctl.kind)
            afu_pkg::K_RELU:  n_fixed = pos ? x : '0;
            afu_pkg::K_DRELU: n_fixed = pos ? afu_pkg::ONE_SAT16 : '0;
            default:          n_fixed = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_p     <= n_p;
        r_prod  <= n_prod;
        r_fixed <= n_fixed;
    end

    assign o_ctl   = r_ctl;
    assign o_p     = r_p;
    assign o_prod  = r_prod;
    assign o_fixed = r_fixed;

endmodule

### hw/rtl/afu_interp.sv
// Second and third stages: table lookup, rounding of x*(1-x), interpolation product.
// Depends on afu_pkg (types, widths and the sigmoid table).
`timescale 1ns / 1ps

module afu_interp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  afu_pkg::t_ctl                        i_ctl,
    input  logic [afu_pkg::P_W-1:0]              i_p,
    input  logic signed [afu_pkg::PROD_W-1:0]    i_prod,
    input  logic signed [afu_pkg::DATA_W-1:0]    i_fixed,
    output afu_pkg::t_ctl                        o_ctl,
    output logic [afu_pkg::ROM_W-1:0]            o_lo,
    output logic [afu_pkg::MUL_W-1:0]            o_mul,
    output logic signed [afu_pkg::DATA_W-1:0]    o_fixed
);

    logic [afu_pkg::IDX_W-1:0]         idx;
    logic [afu_pkg::ROM_W-1:0]         lo;
    logic [afu_pkg::ROM_W-1:0]         hi;
    logic signed [afu_pkg::PROD_W-1:0] rnd;
    logic signed [afu_pkg::PROD_W-1:0] shr;
    logic                              fits;

    afu_pkg::t_ctl                     n_s2_ctl;
    logic [afu_pkg::ROM_W-1:0]         n_s2_diff;
    logic signed [afu_pkg::DATA_W-1:0] n_s2_fixed;
    logic [afu_pkg::MUL_W-1:0]         n_s3_mul;

    afu_pkg::t_ctl                     r_s2_ctl;
    logic [afu_pkg::ROM_W-1:0]         r_s2_lo;
    logic [afu_pkg::ROM_W-1:0]         r_s2_diff;
    logic [afu_pkg::POS_SHIFT-1:0]     r_s2_fr;
    logic signed [afu_pkg::DATA_W-1:0] r_s2_fixed;

    afu_pkg::t_ctl                     r_s3_ctl;
    logic [afu_pkg::ROM_W-1:0]         r_s3_lo;
    logic [afu_pkg::MUL_W-1:0]         r_s3_mul;
    logic signed [afu_pkg::DATA_W-1:0] r_s3_fixed;

    always_comb begin
        // out of table range the index is unused; hold it at zero
        idx = i_ctl.beyond ? '0 : i_p[afu_pkg::POS_SHIFT +: afu_pkg::IDX_W];
        lo  = afu_pkg::SIG_ROM[idx];
        hi  = afu_pkg::SIG_ROM[idx + afu_pkg::IDX_W'(1)];
        n_s2_diff = (hi >= lo) ? (hi - lo) : '0;

        // round to nearest, ties upward, then floor shift
        rnd  = i_prod + afu_pkg::PROD_W'(afu_pkg::ONE_Q >> 1);
        shr  = rnd >>> afu_pkg::FRACTION_BITS;
        fits = (&shr[afu_pkg::PROD_W-1:afu_pkg::DATA_W-1])
             | ~(|shr[afu_pkg::PROD_W-1:afu_pkg::DATA_W-1]);

        n_s2_ctl = i_ctl;
        if (i_ctl.kind == afu_pkg::K_DSIG) begin
            if (fits) begin
                n_s2_fixed = shr[afu_pkg::DATA_W-1:0];
            end else begin
                n_s2_fixed = shr[afu_pkg::PROD_W-1] ? 16'sh8000 : 16'sh7FFF;
            end
        end else begin
            n_s2_fixed = i_fixed;
        end

        n_s3_mul = afu_pkg::MUL_W'(r_s2_diff) * afu_pkg::MUL_W'(r_s2_fr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else begin
            r_s2_ctl <= n_s2_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
        r_s2_lo    <= lo;
        r_s2_diff  <= n_s2_diff;
        r_s2_fr    <= i_p[afu_pkg::POS_SHIFT-1:0];
        r_s2_fixed <= n_s2_fixed;

        r_s3_lo    <= r_s2_lo;
        r_s3_mul   <= n_s3_mul;
        r_s3_fixed <= r_s2_fixed;
    end

    assign o_ctl   = r_s3_ctl;
    assign o_lo    = r_s3_lo;
    assign o_mul   = r_s3_mul;
    assign o_fixed = r_s3_fixed;

endmodule

### hw/rtl/afu_back.sv
// Last stage: finish the interpolation, mirror, saturate and select the result.
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  afu_pkg::t_ctl                     i_ctl,
    input  logic [afu_pkg::ROM_W-1:0]         i_lo,
    input  logic [afu_pkg::MUL_W-1:0]         i_mul,
    input  logic signed [afu_pkg::DATA_W-1:0] i_fixed,
    output logic                              o_strobe,
    output afu_pkg::t_out_item                o_result
);

    logic [afu_pkg::MUL_W:0]           rnd;
    logic [afu_pkg::ROM_W-1:0]         add;
    logic [afu_pkg::SIG_W-1:0]         s_abs;
    logic [afu_pkg::SIG_W-1:0]         s_val;
    logic signed [afu_pkg::DATA_W-1:0] sig_res;

    afu_pkg::t_out_item                n_result;
    afu_pkg::t_out_item                r_result;
    logic                              r_strobe;

    always_comb begin
        rnd   = {1'b0, i_mul} + ((afu_pkg::MUL_W + 1)'(1) << (afu_pkg::POS_SHIFT - 1));
        add   = rnd[afu_pkg::POS_SHIFT +: afu_pkg::ROM_W];
        s_abs = i_ctl.beyond ? afu_pkg::SIG_W'(afu_pkg::ONE_Q)
                             : afu_pkg::SIG_W'(i_lo) + afu_pkg::SIG_W'(add);
        // mirror for negative operands
        s_val = i_ctl.neg ? (afu_pkg::SIG_W'(afu_pkg::ONE_Q) - s_abs) : s_abs;
        if (32'(s_val) > 32'd32767) begin
            sig_res = 16'sh7FFF;
        end else begin
            sig_res = afu_pkg::DATA_W'(s_val);
        end

        n_result.invalid_kind = 1'b0;
        case (i_ctl.kind)
            afu_pkg::K_SIG: begin
                n_result.result_value = sig_res;
            end
            afu_pkg::K_BAD: begin
                n_result.result_value = '0;
                n_result.invalid_kind = 1'b1;
            end
            default: begin
                n_result.result_value = i_fixed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hw/rtl/activation_function_unit.sv
// Top level of the activation unit: ReLU and sigmoid with their derivatives, Q4.11.
// Depends on afu_pkg, afu_front, afu_interp and afu_back.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive i_item (x_value, opcode, want_derivative) and raise start.
//   The item is taken at a rising edge where start is high and busy is low; busy
//   never rises, so a new item may be offered in every cycle.
//   Result channel: o_strobe is high for exactly one cycle with o_result valid
//   (result_value and invalid_kind). The receiver must take it in that cycle;
//   there is no way to hold results back, and none is needed.
//   Throughput: one item per cycle, sustained. The four register stages are front
//   (decode, |x| times table size, x*(1-x)), lookup and rounding, interpolation
//   product, and mirror/saturate/select; the deepest paths are the two
//   multipliers, one per stage.
//   Reset (i_rst_n low, synchronous) clears the valid bits of every stage, so
//   items in flight are dropped and no strobe follows. The sigmoid table is a
//   constant, so no clearing pass is needed.
//   Opcodes 2 and 3 give result_value zero with invalid_kind set.
module activation_function_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  afu_pkg::t_in_item       i_item,
    output logic                    o_strobe,
    output afu_pkg::t_out_item      o_result
);

    afu_pkg::t_ctl                     s1_ctl;
    logic [afu_pkg::P_W-1:0]           s1_p;
    logic signed [afu_pkg::PROD_W-1:0] s1_prod;
    logic signed [afu_pkg::DATA_W-1:0] s1_fixed;

    afu_pkg::t_ctl                     s3_ctl;
    logic [afu_pkg::ROM_W-1:0]         s3_lo;
    logic [afu_pkg::MUL_W-1:0]         s3_mul;
    logic signed [afu_pkg::DATA_W-1:0] s3_fixed;

    // the pipeline never stalls, so every offered item is taken
    assign busy = 1'b0;

    afu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_ctl   (s1_ctl),
        .o_p     (s1_p),
        .o_prod  (s1_prod),
        .o_fixed (s1_fixed)
    );

    afu_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_p     (s1_p),
        .i_prod  (s1_prod),
        .i_fixed (s1_fixed),
        .o_ctl   (s3_ctl),
        .o_lo    (s3_lo),
        .o_mul   (s3_mul),
        .o_fixed (s3_fixed)
    );

    afu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s3_ctl),
        .i_lo     (s3_lo),
        .i_mul    (s3_mul),
        .i_fixed  (s3_fixed),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // every accepted item leaves the pipeline with a strobe
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted item did not emerge after four cycles");

    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("strobe without a matching accepted item");

    // invalid flag follows the opcode of the same item, with a zero result
    a_invalid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.invalid_kind ==
            ($past(i_item.opcode, 4) != afu_pkg::OP_RELU &&
             $past(i_item.opcode, 4) != afu_pkg::OP_SIGMOID)) &&
            (!o_result.invalid_kind || o_result.result_value == 16'sd0))
        else $error("invalid flag or its zero result is wrong");

    // a sigmoid value is never negative
    a_sigmoid_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_item.opcode == afu_pkg::OP_SIGMOID &&
                           !i_item.want_derivative, 4))
        |-> !o_result.result_value[afu_pkg::DATA_W-1])
        else $error("negative sigmoid result");

endmodule
